/* rtl/core/ecv_pkg.sv */
// shared types, constants and the arctangent table for the euler camera view core
// no dependencies; imported by every module of the core
package ecv_pkg;

  localparam int DW = 32;
  localparam int FB = 16;

  typedef logic signed [DW-1:0] q_t;
  typedef q_t [2:0] vec3_t;

  typedef enum logic [2:0] {
    REQ_MOVE       = 3'd0,
    REQ_ROTATE     = 3'd1,
    REQ_SET_ANGLES = 3'd2,
    REQ_MOVE_FWD   = 3'd3,
    REQ_GET_VIEW   = 3'd4
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE,
    ST_ANG,
    ST_MODSTEP,
    ST_YAWFIX,
    ST_TRIG_START,
    ST_TRIG_WAIT,
    ST_MUL_ISSUE,
    ST_MUL_WB,
    ST_NORM_START,
    ST_NORM_WAIT,
    ST_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    NS_IDLE,
    NS_SQ,
    NS_SQRT,
    NS_DIV_LOAD,
    NS_DIV
  } norm_state_t;

  // degree constants in q16.16
  localparam q_t DEG360_Q   = 32'sd23592960;
  localparam q_t PITCH_LIM  = 32'sd5832704;
  localparam q_t TURN_LIM   = 32'sd11796480;
  localparam q_t ONE_Q      = 32'sd65536;
  localparam logic signed [18:0] NORM_LIM = 19'sd131072;

  // cordic angles in q.24 degrees
  localparam int ANG_W = 35;
  localparam logic signed [ANG_W-1:0] ANG_FULL = 35'sd6039797760;
  localparam logic signed [ANG_W-1:0] ANG_Q90  = 35'sd1509949440;
  localparam logic signed [ANG_W-1:0] ANG_Q180 = 35'sd3019898880;
  localparam logic signed [ANG_W-1:0] ANG_Q270 = 35'sd4529848320;
  localparam int XY_W = 34;
  localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam int CORDIC_STEPS = 24;

  function automatic logic [31:0] atan_deg(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd754974720;
      5'd1:  v = 32'd445687602;
      5'd2:  v = 32'd235489088;
      5'd3:  v = 32'd119537938;
      5'd4:  v = 32'd60000934;
      5'd5:  v = 32'd30029717;
      5'd6:  v = 32'd15018523;
      5'd7:  v = 32'd7509720;
      5'd8:  v = 32'd3754917;
      5'd9:  v = 32'd1877466;
      5'd10: v = 32'd938734;
      5'd11: v = 32'd469367;
      5'd12: v = 32'd234684;
      5'd13: v = 32'd117342;
      5'd14: v = 32'd58671;
      5'd15: v = 32'd29335;
      5'd16: v = 32'd14668;
      5'd17: v = 32'd7334;
      5'd18: v = 32'd3667;
      5'd19: v = 32'd1833;
      5'd20: v = 32'd917;
      5'd21: v = 32'd458;
      5'd22: v = 32'd229;
      5'd23: v = 32'd115;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/ecv_mul.sv */
// shared q16.16 multiplier with a registered, floor-truncated product
// depends on ecv_pkg
module ecv_mul (
  input  logic          clk,
  input  ecv_pkg::q_t   a,
  input  ecv_pkg::q_t   b,
  output ecv_pkg::q_t   q
);
  import ecv_pkg::*;

  logic signed [2*DW-1:0] prod;
  q_t q_r;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    q_r <= prod[DW+FB-1:FB];
  end

  assign q = q_r;

endmodule

/* rtl/core/ecv_cordic.sv */
// iterative cordic sine and cosine of an angle in q16.16 degrees, one rotation a cycle
// depends on ecv_pkg
module ecv_cordic (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  ecv_pkg::q_t ang,
  output logic        done,
  output ecv_pkg::q_t co,
  output ecv_pkg::q_t si
);
  import ecv_pkg::*;

  logic                    busy_r;
  logic [4:0]              step_r;
  logic signed [ANG_W-1:0] a_r;
  logic signed [XY_W-1:0]  x_r, y_r;
  logic                    flip_r;
  logic                    done_r;
  q_t                      co_r, si_r;

  logic signed [ANG_W-1:0] a0, a1, a2, at;
  logic                    flip0;
  logic signed [XY_W-1:0]  xs, ys, xn, yn, xf, yf;

  always_comb begin
    // fold the angle into [-90, 90] and remember a half turn
    a0 = {ang[26:0], 8'b0};
    a1 = a0[ANG_W-1] ? a0 + ANG_FULL : a0;
    flip0 = 1'b0;
    if (a1 >= ANG_Q270) begin
      a2 = a1 - ANG_FULL;
    end else if (a1 > ANG_Q90) begin
      a2 = a1 - ANG_Q180;
      flip0 = 1'b1;
    end else begin
      a2 = a1;
    end
    at = ANG_W'($signed({1'b0, atan_deg(step_r)}));
    xs = x_r >>> step_r;
    ys = y_r >>> step_r;
    if (!a_r[ANG_W-1]) begin
      xn = x_r - ys;
      yn = y_r + xs;
    end else begin
      xn = x_r + ys;
      yn = y_r - xs;
    end
    xf = flip_r ? -xn : xn;
    yf = flip_r ? -yn : yn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == 5'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a2;
      flip_r <= flip0;
      x_r    <= CORDIC_X0;
      y_r    <= '0;
    end else if (busy_r) begin
      x_r <= xn;
      y_r <= yn;
      a_r <= a_r[ANG_W-1] ? a_r + at : a_r - at;
      if (step_r == 5'(CORDIC_STEPS - 1)) begin
        co_r <= DW'(xf >>> 14);
        si_r <= DW'(yf >>> 14);
      end
    end
  end

  assign done = done_r;
  assign co   = co_r;
  assign si   = si_r;

endmodule

/* rtl/core/ecv_norm.sv */
// vector normalizer: clamp, sum of squares, bit-pair square root, restoring divide
// depends on ecv_pkg
module ecv_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  ecv_pkg::vec3_t vin,
  output logic           done,
  output ecv_pkg::vec3_t vout
);
  import ecv_pkg::*;

  norm_state_t state_r, state_nxt;

  logic signed [18:0] c_r [3];
  logic [36:0]        sum_r;
  logic [36:0]        n_r, res_r;
  logic [5:0]         e_r;
  logic [1:0]         idx_r;
  logic [33:0]        quo_r;
  logic [19:0]        rem_r;
  logic [5:0]         cnt_r;
  logic               neg_r;
  logic               done_r;
  vec3_t              o_r;

  logic signed [18:0] clamp_v [3];
  logic signed [37:0] sq;
  logic [36:0]        sum_n;
  logic [36:0]        bitv;
  logic [37:0]        trial;
  logic [18:0]        len;
  logic [19:0]        t;
  logic               qbit;
  logic [33:0]        quo_n;
  logic [33:0]        sgn_q;
  logic [17:0]        mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (vin[i] < DW'(-NORM_LIM)) begin
        clamp_v[i] = -NORM_LIM;
      end else if (vin[i] > DW'(NORM_LIM)) begin
        clamp_v[i] = NORM_LIM;
      end else begin
        clamp_v[i] = vin[i][18:0];
      end
    end
    sq    = c_r[idx_r] * c_r[idx_r];
    sum_n = sum_r + sq[36:0];
    bitv  = 37'd1 << e_r;
    trial = {1'b0, res_r} + {1'b0, bitv};
    len   = res_r[18:0];
    t     = {rem_r[18:0], quo_r[33]};
    qbit  = (t >= {1'b0, len});
    quo_n = {quo_r[32:0], qbit};
    sgn_q = neg_r ? -quo_n : quo_n;
    mag   = 18'(c_r[idx_r][18] ? -c_r[idx_r] : c_r[idx_r]);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      NS_IDLE:     if (start) state_nxt = NS_SQ;
      NS_SQ:       if (idx_r == 2'd2) state_nxt = NS_SQRT;
      NS_SQRT:     if (e_r == 6'd0) state_nxt = NS_DIV_LOAD;
      NS_DIV_LOAD: state_nxt = NS_DIV;
      NS_DIV: begin
        if (cnt_r == 6'd33) begin
          state_nxt = (idx_r == 2'd2) ? NS_IDLE : NS_DIV_LOAD;
        end
      end
      default:     state_nxt = NS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= NS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == NS_DIV) && (cnt_r == 6'd33) && (idx_r == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      NS_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) c_r[i] <= clamp_v[i];
          sum_r <= '0;
          idx_r <= '0;
        end
      end
      NS_SQ: begin
        sum_r <= sum_n;
        idx_r <= idx_r + 2'd1;
        if (idx_r == 2'd2) begin
          n_r   <= sum_n;
          res_r <= '0;
          e_r   <= 6'd36;
          idx_r <= '0;
        end
      end
      NS_SQRT: begin
        if ({1'b0, n_r} >= trial) begin
          n_r   <= n_r - trial[36:0];
          res_r <= (res_r >> 1) + bitv;
        end else begin
          res_r <= res_r >> 1;
        end
        e_r <= e_r - 6'd2;
      end
      NS_DIV_LOAD: begin
        neg_r <= c_r[idx_r][18];
        quo_r <= {mag, 16'b0};
        rem_r <= '0;
        cnt_r <= '0;
      end
      NS_DIV: begin
        rem_r <= qbit ? t - {1'b0, len} : t;
        quo_r <= quo_n;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd33) begin
          // zero length gives the zero vector
          o_r[idx_r] <= (len == '0) ? '0 : sgn_q[DW-1:0];
          idx_r <= idx_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign vout = o_r;

endmodule

/* rtl/core/euler_camera_view_matrix_core.sv */
// top level of the euler camera view core: request sequencer, camera state, row output
// depends on ecv_pkg, ecv_mul, ecv_cordic, ecv_norm
//
//  channel | dir | tdata (low bit up)                         | tuser    | tlast
//  in_     | in  | vec_x, vec_y, vec_z, distance (128)        | req_type | -
//  out_    | out | row_index, col0, col1, col2, col3, 6'b0    | -        | last_row
//
// move forward makes three passes of the shared multiplier. rotate and set angles run
// a 7-step modulo, two cordic runs and a normalize dominated by three 34-step divides.
// get view runs two normalizes and 15 products.
// reset puts the camera at the origin looking along +x; in_tready is low while busy,
// and rows hold on out_tdata while out_tready is low.
module euler_camera_view_matrix_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // vec_x, vec_y, vec_z, distance
  input  logic [2:0]   in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // row_index, col0, col1, col2, col3, zero pad
  output logic         out_tlast
);
  import ecv_pkg::*;

  top_state_t state_r, state_nxt;

  req_t  req_r;
  q_t    vx_r, vy_r, vz_r, dist_r;
  vec3_t pos_r, fwd_r, f_r, s_r, u_r, nvec_r;
  q_t    yaw_r, pitch_r;
  q_t    cy_r, sy_r, cp_r, sp_r;
  q_t    acc_r, r0t_r, r1t_r, r2t_r;
  logic [31:0] rem_r;
  logic [2:0]  modk_r;
  logic [3:0]  mi_r;
  logic [1:0]  row_r;
  logic        view_stage_r;
  logic        trig_sel_r;

  q_t    mul_a, mul_b, mul_q;
  logic  mul_last;
  logic  cordic_start, cordic_done;
  q_t    cordic_co, cordic_si;
  logic  norm_start, norm_done;
  vec3_t norm_out;

  logic  in_acc, out_acc;
  req_t  in_req;
  logic signed [32:0] pinc, psum, pbase;
  q_t    pnew;
  logic [31:0] csh, ymod;
  logic [25:0] ysum;
  q_t    c0, c1, c2, c3;

  assign in_req  = req_t'(in_tuser);
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  ecv_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mul_q)
  );

  ecv_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .ang   (trig_sel_r ? pitch_r : yaw_r),
    .done  (cordic_done),
    .co    (cordic_co),
    .si    (cordic_si)
  );

  ecv_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vin   (nvec_r),
    .done  (norm_done),
    .vout  (norm_out)
  );

  // angle arithmetic
  always_comb begin
    if (vy_r > TURN_LIM) begin
      pinc = 33'(TURN_LIM);
    end else if (vy_r < -TURN_LIM) begin
      pinc = -33'(TURN_LIM);
    end else begin
      pinc = 33'(vy_r);
    end
    pbase = (req_r == REQ_ROTATE) ? 33'(pitch_r) : 33'sd0;
    psum  = pbase + pinc;
    if (psum > 33'(PITCH_LIM)) begin
      pnew = PITCH_LIM;
    end else if (psum < -33'(PITCH_LIM)) begin
      pnew = -PITCH_LIM;
    end else begin
      pnew = psum[31:0];
    end
    csh  = 32'(DEG360_Q) << modk_r;
    ymod = (vx_r[31] && rem_r != '0) ? 32'(DEG360_Q) - rem_r : rem_r;
    ysum = ymod[25:0] + yaw_r[25:0];
  end

  // operands of the shared multiplier
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_last = 1'b0;
    unique case (req_r)
      REQ_ROTATE, REQ_SET_ANGLES: begin
        mul_a    = (mi_r == 4'd0) ? cy_r : sy_r;
        mul_b    = cp_r;
        mul_last = (mi_r == 4'd1);
      end
      REQ_MOVE_FWD: begin
        mul_a    = fwd_r[mi_r[1:0]];
        mul_b    = dist_r;
        mul_last = (mi_r == 4'd2);
      end
      REQ_GET_VIEW: begin
        mul_last = (mi_r == 4'd14);
        unique case (mi_r)
          4'd0:  begin mul_a = s_r[1]; mul_b = f_r[2]; end
          4'd1:  begin mul_a = s_r[2]; mul_b = f_r[1]; end
          4'd2:  begin mul_a = s_r[2]; mul_b = f_r[0]; end
          4'd3:  begin mul_a = s_r[0]; mul_b = f_r[2]; end
          4'd4:  begin mul_a = s_r[0]; mul_b = f_r[1]; end
          4'd5:  begin mul_a = s_r[1]; mul_b = f_r[0]; end
          4'd6:  begin mul_a = s_r[0]; mul_b = pos_r[0]; end
          4'd7:  begin mul_a = s_r[1]; mul_b = pos_r[1]; end
          4'd8:  begin mul_a = s_r[2]; mul_b = pos_r[2]; end
          4'd9:  begin mul_a = u_r[0]; mul_b = pos_r[0]; end
          4'd10: begin mul_a = u_r[1]; mul_b = pos_r[1]; end
          4'd11: begin mul_a = u_r[2]; mul_b = pos_r[2]; end
          4'd12: begin mul_a = f_r[0]; mul_b = pos_r[0]; end
          4'd13: begin mul_a = f_r[1]; mul_b = pos_r[1]; end
          4'd14: begin mul_a = f_r[2]; mul_b = pos_r[2]; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // sequencer next state and handshakes
  always_comb begin
    state_nxt    = state_r;
    in_tready    = (state_r == ST_IDLE);
    out_tvalid   = (state_r == ST_OUT);
    cordic_start = (state_r == ST_TRIG_START);
    norm_start   = (state_r == ST_NORM_START);
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_req)
            REQ_MOVE:                   state_nxt = ST_MOVE;
            REQ_ROTATE, REQ_SET_ANGLES: state_nxt = ST_ANG;
            REQ_MOVE_FWD:               state_nxt = ST_MUL_ISSUE;
            REQ_GET_VIEW:               state_nxt = ST_NORM_START;
            default:                    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MOVE:       state_nxt = ST_IDLE;
      ST_ANG:        state_nxt = ST_MODSTEP;
      ST_MODSTEP:    if (modk_r == 3'd0) state_nxt = ST_YAWFIX;
      ST_YAWFIX:     state_nxt = ST_TRIG_START;
      ST_TRIG_START: state_nxt = ST_TRIG_WAIT;
      ST_TRIG_WAIT: begin
        if (cordic_done) state_nxt = trig_sel_r ? ST_MUL_ISSUE : ST_TRIG_START;
      end
      ST_MUL_ISSUE:  state_nxt = ST_MUL_WB;
      ST_MUL_WB: begin
        if (!mul_last) begin
          state_nxt = ST_MUL_ISSUE;
        end else begin
          unique case (req_r)
            REQ_ROTATE, REQ_SET_ANGLES: state_nxt = ST_NORM_START;
            REQ_GET_VIEW:               state_nxt = ST_OUT;
            default:                    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_NORM_START: state_nxt = ST_NORM_WAIT;
      ST_NORM_WAIT: begin
        if (norm_done) begin
          if (req_r != REQ_GET_VIEW) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = view_stage_r ? ST_MUL_ISSUE : ST_NORM_START;
          end
        end
      end
      ST_OUT:        if (out_acc && row_r == 2'd3) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      yaw_r   <= '0;
      pitch_r <= '0;
      fwd_r   <= '{32'sd0, 32'sd0, ONE_Q};
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_MOVE: begin
          pos_r[0] <= pos_r[0] + vx_r;
          pos_r[1] <= pos_r[1] + vy_r;
          pos_r[2] <= pos_r[2] + vz_r;
        end
        ST_ANG: pitch_r <= pnew;
        ST_YAWFIX: begin
          if (req_r == REQ_ROTATE) begin
            yaw_r <= (ysum >= 26'(DEG360_Q)) ? DW'(ysum - 26'(DEG360_Q)) : DW'(ysum);
          end else begin
            yaw_r <= ymod;
          end
        end
        ST_MUL_WB: begin
          if (req_r == REQ_MOVE_FWD) pos_r[mi_r[1:0]] <= pos_r[mi_r[1:0]] + mul_q;
        end
        ST_NORM_WAIT: begin
          if (norm_done && req_r != REQ_GET_VIEW) fwd_r <= norm_out;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_r        <= in_req;
          vx_r         <= in_tdata[31:0];
          vy_r         <= in_tdata[63:32];
          vz_r         <= in_tdata[95:64];
          dist_r       <= in_tdata[127:96];
          mi_r         <= '0;
          view_stage_r <= 1'b0;
          nvec_r       <= fwd_r;
        end
      end
      ST_ANG: begin
        rem_r  <= vx_r[31] ? 32'(-vx_r) : vx_r;
        modk_r <= 3'd6;
      end
      ST_MODSTEP: begin
        if (rem_r >= csh) rem_r <= rem_r - csh;
        modk_r <= modk_r - 3'd1;
      end
      ST_YAWFIX: trig_sel_r <= 1'b0;
      ST_TRIG_WAIT: begin
        if (cordic_done) begin
          if (!trig_sel_r) begin
            cy_r       <= cordic_co;
            sy_r       <= cordic_si;
            trig_sel_r <= 1'b1;
          end else begin
            cp_r <= cordic_co;
            sp_r <= cordic_si;
            mi_r <= '0;
          end
        end
      end
      ST_MUL_WB: begin
        mi_r <= mi_r + 4'd1;
        unique case (req_r)
          REQ_ROTATE, REQ_SET_ANGLES: begin
            if (mi_r == 4'd0) begin
              nvec_r[0] <= mul_q;
            end else begin
              nvec_r[1] <= sp_r;
              nvec_r[2] <= mul_q;
            end
          end
          REQ_GET_VIEW: begin
            // cross product then three dot products with the position
            unique case (mi_r)
              4'd0, 4'd2, 4'd4, 4'd6, 4'd9, 4'd12: acc_r <= mul_q;
              4'd1:  u_r[0] <= acc_r - mul_q;
              4'd3:  u_r[1] <= acc_r - mul_q;
              4'd5:  u_r[2] <= acc_r - mul_q;
              4'd7, 4'd10, 4'd13: acc_r <= acc_r + mul_q;
              4'd8:  r0t_r <= -(acc_r + mul_q);
              4'd11: r1t_r <= -(acc_r + mul_q);
              4'd14: r2t_r <= acc_r + mul_q;
              default: ;
            endcase
            row_r <= '0;
          end
          default: ;
        endcase
      end
      ST_NORM_WAIT: begin
        if (norm_done && req_r == REQ_GET_VIEW) begin
          if (!view_stage_r) begin
            f_r          <= norm_out;
            nvec_r[0]    <= -norm_out[2];
            nvec_r[1]    <= '0;
            nvec_r[2]    <= norm_out[0];
            view_stage_r <= 1'b1;
          end else begin
            s_r  <= norm_out;
            mi_r <= '0;
          end
        end
      end
      ST_OUT: if (out_acc) row_r <= row_r + 2'd1;
      default: ;
    endcase
  end

  // row select for the output beat
  always_comb begin
    unique case (row_r)
      2'd0: begin c0 = s_r[0]; c1 = s_r[1]; c2 = s_r[2]; c3 = r0t_r; end
      2'd1: begin c0 = u_r[0]; c1 = u_r[1]; c2 = u_r[2]; c3 = r1t_r; end
      2'd2: begin c0 = -f_r[0]; c1 = -f_r[1]; c2 = -f_r[2]; c3 = r2t_r; end
      default: begin c0 = '0; c1 = '0; c2 = '0; c3 = ONE_Q; end
    endcase
  end

  assign out_tdata = {6'b0, c3, c2, c1, c0, row_r};
  assign out_tlast = (row_r == 2'd3);

endmodule
